[src/rsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared types and constants for the radius search filter: register indexes,
// fixed result field widths and the queue entry carried from front to back.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int unsigned IndexW    = 32;
  localparam int unsigned DistW     = 50;
  localparam int unsigned TotalW    = 17;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 50;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUERY_X        = 3'd0,
    CFG_QUERY_Y        = 3'd1,
    CFG_QUERY_Z        = 3'd2,
    CFG_RADIUS_SQUARED = 3'd3,
    CFG_START_INDEX    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [IndexW-1:0] point_index;
    logic [DistW-1:0]  distance_squared;
    logic              is_match;
    logic              window_done;
  } rsf_item_t;

  typedef struct packed {
    logic      valid;
    rsf_item_t item;
  } rsf_slot_t;

endpackage

[src/radius_search_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_search_filter_core
// Fixed-radius neighbour search over a stream of window points.
// ----------------------------------------------------------------------------
// Takes one point per clock cycle, sustained, as long as results are taken.
// Each point passes two register stages (coordinate differences, then the
// three squares) before the sum, saturation to 50 bits and radius compare
// that decide whether it enters an 8-entry queue; the output register
// follows the queue. Points are admitted only while the queue has a free slot
// for every point still in the distance pipeline, so a held output backs up
// into in_stall_o after the queue fills. Only matches and the last point of
// each window give a result; the last one carries window_done and the window's
// match total. Registers are written through the configuration port, by the
// user only while no point is in flight; the block does not enforce this.
// cfg_ready_o is always high and indexes past start_index are ignored.
// ----------------------------------------------------------------------------
module radius_search_filter_core #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned MAX_WINDOW  = 65536,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rsf_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  input  logic signed [COORD_BITS-1:0]      point_z_i,
  input  logic                              window_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rsf_pkg::IndexW-1:0]        point_index_o,
  output logic [rsf_pkg::DistW-1:0]         distance_squared_o,
  output logic                              is_match_o,
  output logic [rsf_pkg::TotalW-1:0]        match_total_o,
  output logic                              window_done_o
);

  rsf_pkg::rsf_slot_t                  push;
  rsf_pkg::rsf_slot_t                  head;
  logic                                pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]    level;

  assign cfg_ready_o = 1'b1;

  rsf_front #(
    .COORD_BITS  (COORD_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .window_end_i (window_end_i),
    .level_i      (level),
    .push_o       (push)
  );

  rsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .level_o (level)
  );

  rsf_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .point_index_o      (point_index_o),
    .distance_squared_o (distance_squared_o),
    .is_match_o         (is_match_o),
    .match_total_o      (match_total_o),
    .window_done_o      (window_done_o)
  );

endmodule

[src/rsf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_front
// Accepts points, forms the squared distance to the query point over two
// register stages and classifies each point; pushes matches and window ends
// into the queue, with admission limited by free queue slots.
// ----------------------------------------------------------------------------
module rsf_front #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_valid_i,
  input  logic [rsf_pkg::CfgIdxW-1:0]               cfg_index_i,
  input  logic [rsf_pkg::CfgDataW-1:0]              cfg_data_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic signed [COORD_BITS-1:0]              point_x_i,
  input  logic signed [COORD_BITS-1:0]              point_y_i,
  input  logic signed [COORD_BITS-1:0]              point_z_i,
  input  logic                                      window_end_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]          level_i,
  output rsf_pkg::rsf_slot_t                        push_o
);

  localparam int unsigned SqW   = 2 * COORD_BITS;
  localparam int unsigned SumW  = SqW + 2;
  localparam int unsigned LvlW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CredW = LvlW + 2;

  logic signed [COORD_BITS-1:0]       query_x_q, query_y_q, query_z_q;
  logic [rsf_pkg::DistW-1:0]          radius_q;
  logic [rsf_pkg::IndexW-1:0]         start_q;
  logic [rsf_pkg::IndexW-1:0]         pos_q, pos_d;

  logic                               s1_v_q, s2_v_q;
  logic [COORD_BITS-1:0]              s1_dx_q, s1_dy_q, s1_dz_q;
  logic [rsf_pkg::IndexW-1:0]         s1_idx_q, s2_idx_q;
  logic                               s1_last_q, s2_last_q;
  logic [SqW-1:0]                     s2_sqx_q, s2_sqy_q, s2_sqz_q;

  logic                               accept;
  logic [CredW-1:0]                   reserved;
  logic [SumW-1:0]                    sum;
  logic [SumW+rsf_pkg::DistW-1:0]     sum_ext;
  logic                               sum_ovf;
  logic [rsf_pkg::DistW-1:0]          dist_sq;
  logic                               match;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  assign reserved   = CredW'(level_i) + CredW'(s1_v_q) + CredW'(s2_v_q);
  assign in_stall_o = reserved >= CredW'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept && window_end_i) begin
      pos_d = '0;
    end else if (accept) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      query_z_q <= '0;
      radius_q  <= '0;
      start_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rsf_pkg::CFG_QUERY_X:        query_x_q <= cfg_data_i[COORD_BITS-1:0];
        rsf_pkg::CFG_QUERY_Y:        query_y_q <= cfg_data_i[COORD_BITS-1:0];
        rsf_pkg::CFG_QUERY_Z:        query_z_q <= cfg_data_i[COORD_BITS-1:0];
        rsf_pkg::CFG_RADIUS_SQUARED: radius_q  <= cfg_data_i[rsf_pkg::DistW-1:0];
        rsf_pkg::CFG_START_INDEX:    start_q   <= cfg_data_i[rsf_pkg::IndexW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  // Stage 1: coordinate differences and global index
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_dx_q   <= abs_diff(point_x_i, query_x_q);
      s1_dy_q   <= abs_diff(point_y_i, query_y_q);
      s1_dz_q   <= abs_diff(point_z_i, query_z_q);
      s1_idx_q  <= start_q + pos_q;
      s1_last_q <= window_end_i;
    end
  end

  // Stage 2: squares
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_sqx_q  <= SqW'(s1_dx_q) * SqW'(s1_dx_q);
      s2_sqy_q  <= SqW'(s1_dy_q) * SqW'(s1_dy_q);
      s2_sqz_q  <= SqW'(s1_dz_q) * SqW'(s1_dz_q);
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Sum, saturate, compare
  assign sum     = SumW'(s2_sqx_q) + SumW'(s2_sqy_q) + SumW'(s2_sqz_q);
  assign sum_ext = {{rsf_pkg::DistW{1'b0}}, sum};
  assign sum_ovf = (sum >> rsf_pkg::DistW) != '0;
  assign dist_sq = sum_ovf ? '1 : sum_ext[rsf_pkg::DistW-1:0];
  assign match   = dist_sq <= radius_q;

  always_comb begin
    push_o                       = '0;
    push_o.valid                 = s2_v_q && (match || s2_last_q);
    push_o.item.point_index      = s2_idx_q;
    push_o.item.distance_squared = dist_sq;
    push_o.item.is_match         = match;
    push_o.item.window_done      = s2_last_q;
  end

`ifndef SYNTH
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> level_i < LvlW'(QUEUE_DEPTH))
    else $error("rsf_front: push into a full queue");

  a_pos_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && window_end_i) |=> pos_q == '0)
    else $error("rsf_front: position not cleared after window end");

  a_pipe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q ##1 s2_v_q)
    else $error("rsf_front: accepted point lost in pipeline");
`endif

endmodule

[src/rsf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_queue
// Short FIFO between the classifying front and the result back end; reports
// its fill level so the front can admit only what will fit.
// ----------------------------------------------------------------------------
module rsf_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rsf_pkg::rsf_slot_t               push_i,
  input  logic                             pop_i,
  output rsf_pkg::rsf_slot_t               head_o,
  output logic [$clog2(DEPTH+1)-1:0]       level_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LvlW = $clog2(DEPTH + 1);

  rsf_pkg::rsf_item_t   mem_q [DEPTH];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [LvlW-1:0]      level_q, level_d;
  logic                 do_pop;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign do_pop       = pop_i && (level_q != '0);
  assign head_o.valid = level_q != '0;
  assign head_o.item  = mem_q[rd_q];
  assign level_o      = level_q;

  always_comb begin
    level_d = level_q;
    if (push_i.valid && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (!push_i.valid && do_pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      level_q <= level_d;
      if (push_i.valid) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.item;
    end
  end

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlW'(DEPTH))
    else $error("rsf_queue: level beyond depth");

  a_level_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.valid && !do_pop) |=> level_q == $past(level_q) + 1'b1)
    else $error("rsf_queue: level did not follow push");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> level_q < LvlW'(DEPTH))
    else $error("rsf_queue: push into a full queue");
`endif

endmodule

[src/rsf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_back
// Takes classified results from the queue, keeps the saturating match count
// of the window and holds each result in the output register until taken.
// ----------------------------------------------------------------------------
module rsf_back #(
  parameter int unsigned MAX_WINDOW = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rsf_pkg::rsf_slot_t                head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rsf_pkg::IndexW-1:0]        point_index_o,
  output logic [rsf_pkg::DistW-1:0]         distance_squared_o,
  output logic                              is_match_o,
  output logic [rsf_pkg::TotalW-1:0]        match_total_o,
  output logic                              window_done_o
);

  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);

  logic [CntW-1:0]                  cnt_q, cnt_d, cnt_next;
  logic [CntW+rsf_pkg::TotalW-1:0]  cnt_ext;
  logic                             out_valid_q;
  rsf_pkg::rsf_item_t               out_q;
  logic [rsf_pkg::TotalW-1:0]       total_q;

  assign pop_o    = head_i.valid && (!out_valid_q || !out_stall_i);
  assign cnt_next = (head_i.item.is_match && (cnt_q < CntW'(MAX_WINDOW)))
                  ? cnt_q + 1'b1 : cnt_q;
  assign cnt_ext  = {{rsf_pkg::TotalW{1'b0}}, cnt_next};

  always_comb begin
    cnt_d = cnt_q;
    if (pop_o) begin
      cnt_d = head_i.item.window_done ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q   <= head_i.item;
      total_q <= cnt_ext[rsf_pkg::TotalW-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign point_index_o      = out_q.point_index;
  assign distance_squared_o = out_q.distance_squared;
  assign is_match_o         = out_q.is_match;
  assign match_total_o      = total_q;
  assign window_done_o      = out_q.window_done;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_WINDOW))
    else $error("rsf_back: match count beyond saturation");

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.item.window_done) |=> cnt_q == '0)
    else $error("rsf_back: match count not cleared after window end");

  a_no_pop_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("rsf_back: result overwritten while stalled");
`endif

endmodule
